>>> src/tsom_pkg.sv
// ----------------------------------------------------------------------------
// tsom_pkg
// Shared types and constants for the two-stacks-in-one-memory block.
// ----------------------------------------------------------------------------
package tsom_pkg;

  localparam int MAX_DEPTH_DEF = 64;
  localparam int WORD_BITS_DEF = 32;
  localparam int CAP_BITS      = 7;
  localparam int DATA_BITS     = 32;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_PUSH_LO = 2'd0,
    CMD_PUSH_UP = 2'd1,
    CMD_POP_LO  = 2'd2,
    CMD_POP_UP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

endpackage

>>> src/two_stacks_one_memory.sv
// ----------------------------------------------------------------------------
// two_stacks_one_memory
// Two LIFO stacks in one word memory: the lower stack grows up from address
// zero, the upper stack grows down from the top of the capacity in use.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------
//   in       | input     | in_valid_i/in_ready_o | cmd_i, push_value_i
//   out      | output    | out_valid_o/out_ready_i | pop_value_o, status_o,
//            |           |                       | full_flag_o, lower_empty_o,
//            |           |                       | upper_empty_o
//   cfg      | input     | cfg_we_i              | cfg_data_i (capacity)
//
// One beat per cycle while results are taken; the result shows in the cycle
// after its input beat. Each beat does at most one memory access: a push
// writes, a pop reads through the registered read port that drives pop_value_o.
// The input stalls only while a result sits in the output register untaken.
// Reset clears both stack counts and sets capacity to 64; memory contents
// are not cleared (no word is popped before it was pushed).
// A capacity write empties both stacks.
// ----------------------------------------------------------------------------
module two_stacks_one_memory
  import tsom_pkg::*;
#(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CAP_BITS-1:0]         cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  cmd_i,
  input  logic signed [DATA_BITS-1:0] push_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DATA_BITS-1:0] pop_value_o,
  output logic [1:0]                  status_o,
  output logic                        full_flag_o,
  output logic                        lower_empty_o,
  output logic                        upper_empty_o
);

  localparam int AddrW = $clog2(MAX_DEPTH);
  localparam int CntW  = $clog2(MAX_DEPTH + 1);
  localparam int ExtW  = (CntW > CAP_BITS) ? CntW : CAP_BITS;

  logic [CAP_BITS-1:0]  cap_q;
  logic [CntW-1:0]      lower_q, lower_d;
  logic [CntW-1:0]      upper_q, upper_d;
  logic [CntW-1:0]      eff_cap;
  logic [CntW:0]        used_now, used_next;
  logic                 full_now;

  logic [WORD_BITS-1:0] mem_q [MAX_DEPTH];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 mem_we, mem_re;
  logic [AddrW-1:0]     mem_addr;
  logic [CntW-1:0]      up_addr;

  logic                 in_fire;
  status_e              status_d, status_q;
  logic                 from_mem_d, from_mem_q;
  logic                 ones_d, ones_q;
  logic                 out_valid_q;
  logic                 full_q, lower_empty_q, upper_empty_q;

  assign in_fire    = in_valid_i & in_ready_o;
  assign in_ready_o = ~out_valid_q | out_ready_i;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CntW'(1);
    end else if (ExtW'(cap_q) > ExtW'(MAX_DEPTH)) begin
      eff_cap = CntW'(MAX_DEPTH);
    end else begin
      eff_cap = CntW'(cap_q);
    end
  end

  assign used_now = {1'b0, lower_q} + {1'b0, upper_q};
  assign full_now = used_now >= {1'b0, eff_cap};

  always_comb begin
    lower_d    = lower_q;
    upper_d    = upper_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    up_addr    = '0;
    mem_addr   = '0;
    status_d   = STATUS_DONE;
    from_mem_d = 1'b0;
    ones_d     = 1'b0;
    if (in_fire) begin
      case (cmd_e'(cmd_i))
        CMD_PUSH_LO: begin
          if (full_now) begin
            status_d = STATUS_FULL;
          end else begin
            mem_we   = 1'b1;
            mem_addr = lower_q[AddrW-1:0];
            lower_d  = lower_q + CntW'(1);
          end
        end
        CMD_PUSH_UP: begin
          if (full_now) begin
            status_d = STATUS_FULL;
          end else begin
            mem_we   = 1'b1;
            up_addr  = eff_cap - upper_q - CntW'(1);
            mem_addr = up_addr[AddrW-1:0];
            upper_d  = upper_q + CntW'(1);
          end
        end
        CMD_POP_LO: begin
          if (lower_q == '0) begin
            status_d = STATUS_EMPTY;
            ones_d   = 1'b1;
          end else begin
            lower_d    = lower_q - CntW'(1);
            mem_re     = 1'b1;
            mem_addr   = lower_d[AddrW-1:0];
            from_mem_d = 1'b1;
          end
        end
        CMD_POP_UP: begin
          if (upper_q == '0) begin
            status_d = STATUS_EMPTY;
            ones_d   = 1'b1;
          end else begin
            up_addr    = eff_cap - upper_q;
            mem_re     = 1'b1;
            mem_addr   = up_addr[AddrW-1:0];
            upper_d    = upper_q - CntW'(1);
            from_mem_d = 1'b1;
          end
        end
        default: begin
          status_d = STATUS_DONE;
        end
      endcase
    end
  end

  assign used_next = {1'b0, lower_d} + {1'b0, upper_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      lower_q     <= '0;
      upper_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q   <= cfg_data_i;
        lower_q <= '0;
        upper_q <= '0;
      end else begin
        lower_q <= lower_d;
        upper_q <= upper_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q      <= status_d;
      from_mem_q    <= from_mem_d;
      ones_q        <= ones_d;
      full_q        <= used_next >= {1'b0, eff_cap};
      lower_empty_q <= lower_d == '0;
      upper_empty_q <= upper_d == '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= WORD_BITS'($unsigned(push_value_i));
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pop_value_o   = from_mem_q ? DATA_BITS'(signed'(rd_data_q)) : (ones_q ? '1 : '0);
  assign status_o      = status_q;
  assign full_flag_o   = full_q;
  assign lower_empty_o = lower_empty_q;
  assign upper_empty_o = upper_empty_q;

  a_used_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_now <= {1'b0, eff_cap})
    else $error("stack counts exceed capacity");

  a_pop_lo_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !cfg_we_i && (cmd_i == CMD_POP_LO) && (lower_q != '0)
    |=> lower_q == $past(lower_q) - CntW'(1))
    else $error("lower pop did not move the lower count");

  a_refused_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !cfg_we_i && full_now && ((cmd_i == CMD_PUSH_LO) || (cmd_i == CMD_PUSH_UP))
    |=> $stable(lower_q) && $stable(upper_q))
    else $error("refused push changed a count");

  a_empty_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == STATUS_EMPTY) |-> (pop_value_o == '1))
    else $error("empty pop did not return all ones");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !in_fire)
    else $error("beat taken while result held");

endmodule

>>> verif/two_stacks_one_memory_tb.sv
// ----------------------------------------------------------------------------
// two_stacks_one_memory_tb
// Drives push and pop beats into the shared-memory stack pair, with bursty
// input and a stalling output. A scoreboard tracks both stack pointers and
// memory contents to predict every result field. Runs many capacity settings,
// including 0 and values past the memory depth.
// ----------------------------------------------------------------------------
module two_stacks_one_memory_tb
  import tsom_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HANG_LIMIT   = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 152;
  localparam int PHASE_COUNT  = 10;

  typedef struct {
    logic [DATA_BITS-1:0] pop_value;
    logic [1:0]           status;
    logic                 full;
    logic                 lower_empty;
    logic                 upper_empty;
  } stack_result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_RHYTHM, RX_SPARSE} rx_mode_e;

  class stack_pair_scoreboard;
    logic [DATA_BITS-1:0] word_store [MAX_DEPTH_DEF];
    int unsigned          lower_count;
    int unsigned          upper_count;
    int unsigned          eff_capacity;
    stack_result_t        pending_results [$];
    int                   errors;
    int                   beats;
    int                   settings;
    int                   full_refusals;
    int                   empty_pops;
    int                   full_seen;

    function new();
      set_capacity(CAP_RESET);
      settings = 0;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] value);
      eff_capacity = value;
      if (eff_capacity < 1) eff_capacity = 1;
      if (eff_capacity > MAX_DEPTH_DEF) eff_capacity = MAX_DEPTH_DEF;
      lower_count = 0;
      upper_count = 0;
      settings++;
    endfunction

    function void note_beat(cmd_e cmd, logic [DATA_BITS-1:0] value);
      stack_result_t r;
      bit            was_full;
      r.pop_value = '0;
      r.status    = STATUS_DONE;
      was_full    = (lower_count + upper_count) >= eff_capacity;
      case (cmd)
        CMD_PUSH_LO: begin
          if (was_full) begin
            r.status = STATUS_FULL;
          end else begin
            word_store[lower_count] = value;
            lower_count++;
          end
        end
        CMD_PUSH_UP: begin
          if (was_full) begin
            r.status = STATUS_FULL;
          end else begin
            upper_count++;
            word_store[eff_capacity - upper_count] = value;
          end
        end
        CMD_POP_LO: begin
          if (lower_count == 0) begin
            r.status    = STATUS_EMPTY;
            r.pop_value = '1;
          end else begin
            lower_count--;
            r.pop_value = word_store[lower_count];
          end
        end
        default: begin
          if (upper_count == 0) begin
            r.status    = STATUS_EMPTY;
            r.pop_value = '1;
          end else begin
            r.pop_value = word_store[eff_capacity - upper_count];
            upper_count--;
          end
        end
      endcase
      r.full        = (lower_count + upper_count) >= eff_capacity;
      r.lower_empty = (lower_count == 0);
      r.upper_empty = (upper_count == 0);
      beats++;
      if (r.status == STATUS_FULL) full_refusals++;
      if (r.status == STATUS_EMPTY) empty_pops++;
      if (r.full) full_seen++;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [DATA_BITS-1:0] want,
                                logic [DATA_BITS-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(stack_result_t got);
      stack_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no command pending");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("pop_value", want.pop_value, got.pop_value);
      compare_field("status", want.status, got.status);
      compare_field("full_flag", want.full, got.full);
      compare_field("lower_empty", want.lower_empty, got.lower_empty);
      compare_field("upper_empty", want.upper_empty, got.upper_empty);
    endfunction
  endclass

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        cfg_we_i     = 1'b0;
  logic [CAP_BITS-1:0]         cfg_data_i   = '0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  logic [1:0]                  cmd_i        = CMD_PUSH_LO;
  logic signed [DATA_BITS-1:0] push_value_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic signed [DATA_BITS-1:0] pop_value_o;
  logic [1:0]                  status_o;
  logic                        full_flag_o;
  logic                        lower_empty_o;
  logic                        upper_empty_o;

  stack_pair_scoreboard sb;
  int                   hold_requests = 0;
  int                   holds_served  = 0;
  int                   quiet_cycles  = 0;

  two_stacks_one_memory uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pop_value_o   (pop_value_o),
    .status_o      (status_o),
    .full_flag_o   (full_flag_o),
    .lower_empty_o (lower_empty_o),
    .upper_empty_o (upper_empty_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check taken beats, then pick next ready.
  always @(posedge clk_i) begin : result_side
    stack_result_t got;
    static rx_mode_e rx_mode   = RX_OPEN;
    static int       mode_left = 0;
    static int       hold_left = 0;
    static int       rhythm    = 0;
    logic            ready_next;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.pop_value   = pop_value_o;
        got.status      = status_o;
        got.full        = full_flag_o;
        got.lower_empty = lower_empty_o;
        got.upper_empty = upper_empty_o;
        sb.check_beat(got);
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        rhythm++;
        case (rx_mode)
          RX_OPEN:   ready_next = 1'b1;
          RX_COIN:   ready_next = $urandom_range(0, 1);
          RX_RHYTHM: ready_next = (rhythm % 4) != 0;
          default:   ready_next = $urandom_range(0, 7) == 0;
        endcase
      end
      out_ready_i <= ready_next;
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == HANG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_cmd(cmd_e cmd, logic [DATA_BITS-1:0] value);
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    push_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(cmd, value);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_capacity(value);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic cmd_e random_cmd(int push_pct);
    bit upper;
    upper = $urandom_range(0, 1);
    if ($urandom_range(0, 99) < push_pct) return upper ? CMD_PUSH_UP : CMD_PUSH_LO;
    return upper ? CMD_POP_UP : CMD_POP_LO;
  endfunction

  function automatic logic [DATA_BITS-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random_phase(int n_items);
    int sent;
    int burst;
    int gap;
    int push_pct;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      for (int i = 0; i < burst && sent < n_items; i++) begin
        send_cmd(random_cmd(push_pct), random_word());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    logic [CAP_BITS-1:0] phase_caps [PHASE_COUNT];
    logic [CAP_BITS-1:0] cap;
    phase_caps = '{7'd4, 7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd9, 7'd33, 7'd100, 7'd63};
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pops, extreme words, LIFO order on both stacks
    send_cmd(CMD_POP_LO, 32'h1234_5678);
    send_cmd(CMD_POP_UP, 32'h0);
    send_cmd(CMD_PUSH_LO, 32'h7fff_ffff);
    send_cmd(CMD_PUSH_LO, 32'h8000_0000);
    send_cmd(CMD_PUSH_UP, 32'h0000_0000);
    send_cmd(CMD_PUSH_UP, 32'hffff_ffff);
    send_cmd(CMD_POP_UP, 32'h0);
    send_cmd(CMD_POP_UP, 32'h0);
    send_cmd(CMD_POP_UP, 32'h0);
    send_cmd(CMD_POP_LO, 32'h0);
    send_cmd(CMD_POP_LO, 32'h0);
    send_cmd(CMD_POP_LO, 32'h0);

    // capacity 0 saturates to one word
    write_capacity(7'd0);
    send_cmd(CMD_PUSH_UP, 32'h5555_aaaa);
    send_cmd(CMD_PUSH_LO, 32'h1);
    send_cmd(CMD_PUSH_UP, 32'h2);
    send_cmd(CMD_POP_LO, 32'h0);
    send_cmd(CMD_POP_UP, 32'h0);
    send_cmd(CMD_PUSH_LO, 32'haaaa_5555);
    send_cmd(CMD_PUSH_UP, 32'h3);
    send_cmd(CMD_POP_LO, 32'h0);

    write_capacity(7'd2);
    send_cmd(CMD_PUSH_LO, 32'hdead_beef);
    send_cmd(CMD_PUSH_UP, 32'h0bad_f00d);
    send_cmd(CMD_PUSH_LO, 32'h4);
    send_cmd(CMD_POP_UP, 32'h0);
    send_cmd(CMD_POP_LO, 32'h0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      cap = (p == 6 || p == 8) ? CAP_BITS'($urandom_range(3, 127)) : phase_caps[p];
      write_capacity(cap);
      if (p == 2 || p == 7) hold_requests++;
      run_random_phase(PHASE_ITEMS);
    end
    in_valid_i <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("Covered %0d beats over %0d capacity settings", sb.beats, sb.settings + 1);
    $display("  %0d pushes refused as full, %0d empty pops, %0d beats left memory full",
             sb.full_refusals, sb.empty_pops, sb.full_seen);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> two_stacks_one_memory.f
src/tsom_pkg.sv
src/two_stacks_one_memory.sv
verif/two_stacks_one_memory_tb.sv
